FILE: design/etq_pkg.sv
// ============================================================================
// etq_pkg: shared types, constants and helpers for the Euler to quaternion block
// Fixed-point constants for the angle reduction, the sine/cosine series and the
// rounded Q30 product used throughout the datapath.
// ============================================================================
package etq_pkg;

    // Internal fraction bits of all trig and product values
    localparam int INT_FRAC = 30;

    // Signed Q30 trig / product value
    typedef logic signed [31:0] trig_t;

    // 1.0 at Q30, as an unsigned series value
    localparam logic [30:0] ONE_Q = 31'h4000_0000;

    // pi * 2^60 and the radian step per angle unit (pi/11520 at Q60)
    localparam logic [63:0] PI_Q60   = 64'h3243_F6A8_885A_308D;
    localparam logic [48:0] UNIT_Q60 = 49'((PI_Q60 + 64'd5760) / 64'd11520);

    // Reciprocals for the series divisors: ceil(2^38 / d), exact for values below 2^30
    localparam int RECIP_SHIFT = 38;
    localparam logic [63:0] RECIP_ONE = 64'd1 << RECIP_SHIFT;

    localparam logic [35:0] SIN_RECIP [5] = '{
        36'((RECIP_ONE + 64'd109) / 64'd110),
        36'((RECIP_ONE + 64'd71)  / 64'd72),
        36'((RECIP_ONE + 64'd41)  / 64'd42),
        36'((RECIP_ONE + 64'd19)  / 64'd20),
        36'((RECIP_ONE + 64'd5)   / 64'd6)
    };
    localparam logic [35:0] COS_RECIP [5] = '{
        36'((RECIP_ONE + 64'd131) / 64'd132),
        36'((RECIP_ONE + 64'd89)  / 64'd90),
        36'((RECIP_ONE + 64'd55)  / 64'd56),
        36'((RECIP_ONE + 64'd29)  / 64'd30),
        36'((RECIP_ONE + 64'd11)  / 64'd12)
    };

    // Half divisors for round-to-nearest before the reciprocal multiply
    localparam logic [6:0] SIN_HALF [5] = '{7'd55, 7'd36, 7'd21, 7'd10, 7'd3};
    localparam logic [6:0] COS_HALF [5] = '{7'd66, 7'd45, 7'd28, 7'd15, 7'd6};

    // Rounded Q30 product with floor shift
    function automatic trig_t mulq(input trig_t a, input trig_t b);
        logic signed [63:0] ae;
        logic signed [63:0] be;
        logic signed [63:0] p;
        ae = a;
        be = b;
        p  = ae * be + 64'sd536870912;
        return p[61:30];
    endfunction

endpackage

FILE: design/euler_to_quaternion_fixed_top.sv
// ============================================================================
// euler_to_quaternion_fixed_top: Euler angles to orientation quaternion
// Fully pipelined conversion of three angles to (w, i, j, k) in signed fixed
// point with a configurable number of fraction bits.
// ============================================================================
// Takes one request per clock while the output side does not stall. The depth
// is set by the sine/cosine block (16 stages), a 32-stage bit-per-cycle square
// root and three parallel 32-stage restoring dividers; the whole pipe holds
// while a finished result waits and the last stage is occupied. frac_bits is
// written through cfg_wr_en/cfg_wr_data and must only change while no request
// is in flight. A degenerate result (no valid w) returns all parts zero with
// m_degenerate set.
module euler_to_quaternion_fixed_top (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               cfg_wr_en,
    input  logic [4:0]         cfg_wr_data,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic signed [15:0] s_angle_x,
    input  logic signed [15:0] s_angle_y,
    input  logic signed [15:0] s_angle_z,
    output logic               m_valid,
    input  logic               m_ready,
    output logic signed [31:0] m_real_part,
    output logic signed [31:0] m_i_part,
    output logic signed [31:0] m_j_part,
    output logic signed [31:0] m_k_part,
    output logic               m_degenerate
);
    import etq_pkg::*;

    localparam int SC_LAT = 16;
    localparam int LAT    = SC_LAT + 3 + 32 + 1 + 1 + 32 + 1;

    // Pipeline control: whole pipe advances unless the output is held
    logic           en;
    logic [LAT-1:0] vld_reg;
    logic [4:0]     frac_bits_reg;

    assign en      = !vld_reg[LAT-1] || m_ready;
    assign s_ready = en;
    assign m_valid = vld_reg[LAT-1];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg       <= '0;
            frac_bits_reg <= 5'd30;
        end else begin
            if (en) begin
                vld_reg <= {vld_reg[LAT-2:0], s_valid};
            end
            if (cfg_wr_en) begin
                frac_bits_reg <= cfg_wr_data;
            end
        end
    end

    // Sine and cosine: 1 = heading (y), 2 = attitude (z), 3 = bank (x)
    trig_t s1, c1, s2, c2, s3, c3;

    etq_sincos u_sc_y (.aclk(aclk), .en(en), .angle(s_angle_y), .sin_out(s1), .cos_out(c1));
    etq_sincos u_sc_z (.aclk(aclk), .en(en), .angle(s_angle_z), .sin_out(s2), .cos_out(c2));
    etq_sincos u_sc_x (.aclk(aclk), .en(en), .angle(s_angle_x), .sin_out(s3), .cos_out(c3));

    // Pairwise products
    trig_t c1c2_reg, c1c3_reg, s1s2_reg, c2c3_reg, c2s3_reg;
    trig_t c1s3_reg, s1c2_reg, s1c3_reg, c1s2_reg, s1s3_reg;
    trig_t s2_reg, s3_reg, c3_reg;

    always_ff @(posedge aclk) begin
        if (en) begin
            c1c2_reg <= mulq(c1, c2);
            c1c3_reg <= mulq(c1, c3);
            s1s2_reg <= mulq(s1, s2);
            c2c3_reg <= mulq(c2, c3);
            c2s3_reg <= mulq(c2, s3);
            c1s3_reg <= mulq(c1, s3);
            s1c2_reg <= mulq(s1, c2);
            s1c3_reg <= mulq(s1, c3);
            c1s2_reg <= mulq(c1, s2);
            s1s3_reg <= mulq(s1, s3);
            s2_reg   <= s2;
            s3_reg   <= s3;
            c3_reg   <= c3;
        end
    end

    // Triple products and partial sums
    trig_t s1s2s3_reg, s1s2c3_reg, c1s2s3_reg, c1s2c3_reg;
    logic signed [35:0] radp_reg, nip_reg, njp_reg, nkp_reg;

    always_ff @(posedge aclk) begin
        if (en) begin
            s1s2s3_reg <= mulq(s1s2_reg, s3_reg);
            s1s2c3_reg <= mulq(s1s2_reg, c3_reg);
            c1s2s3_reg <= mulq(c1s2_reg, s3_reg);
            c1s2c3_reg <= mulq(c1s2_reg, c3_reg);
            radp_reg   <= 36'sd1073741824 + 36'(c1c2_reg) + 36'(c1c3_reg) + 36'(c2c3_reg);
            nip_reg    <= 36'(c2s3_reg) + 36'(c1s3_reg);
            njp_reg    <= 36'(s1c2_reg) + 36'(s1c3_reg);
            nkp_reg    <= 36'(s2_reg) - 36'(s1s3_reg);
        end
    end

    // Final sums and square root setup
    logic signed [35:0] rad;
    logic [63:0]        sq_rem_reg  [0:32];
    logic [31:0]        sq_root_reg [0:32];
    logic signed [35:0] sq_n_reg    [0:32][0:2];
    logic               sq_bad_reg  [0:32];

    assign rad = radp_reg - 36'(s1s2s3_reg);

    always_ff @(posedge aclk) begin
        if (en) begin
            sq_rem_reg[0]  <= (rad > 36'sd0) ? ({28'b0, rad} << INT_FRAC) : 64'd0;
            sq_root_reg[0] <= '0;
            sq_bad_reg[0]  <= (rad <= 36'sd0);
            sq_n_reg[0][0] <= nip_reg + 36'(s1s2c3_reg);
            sq_n_reg[0][1] <= njp_reg + 36'(c1s2s3_reg);
            sq_n_reg[0][2] <= 36'(c1s2c3_reg) + nkp_reg;
        end
    end

    // Square root, one result bit per stage from the top
    for (genvar m = 1; m <= 32; m++) begin : g_sqrt
        localparam int B = 32 - m;
        logic [64:0] trial;
        logic        take;
        assign trial = ({33'b0, sq_root_reg[m-1]} << (B + 1)) | (65'd1 << (2 * B));
        assign take  = ({1'b0, sq_rem_reg[m-1]} >= trial);
        always_ff @(posedge aclk) begin
            if (en) begin
                sq_rem_reg[m]  <= take ? 64'(sq_rem_reg[m-1] - trial[63:0]) : sq_rem_reg[m-1];
                sq_root_reg[m] <= take ? (sq_root_reg[m-1] | (32'd1 << B)) : sq_root_reg[m-1];
                sq_bad_reg[m]  <= sq_bad_reg[m-1];
                sq_n_reg[m]    <= sq_n_reg[m-1];
            end
        end
    end

    // Output prep: degenerate test, real part, dividends
    logic [31:0] dd;
    logic [32:0] realm;
    logic [35:0] nmag [0:2];
    logic        pp_degen_reg;
    logic [31:0] pp_real_reg;
    logic [32:0] pp_dv_reg;
    logic [64:0] pp_num_reg [0:2];
    logic        pp_neg_reg [0:2];

    assign dd = sq_root_reg[32];

    always_comb begin
        if (frac_bits_reg == 5'd31) begin
            realm = {1'b0, dd};
        end else begin
            realm = ({1'b0, dd} + (33'd1 << (5'd30 - frac_bits_reg))) >> (5'd31 - frac_bits_reg);
        end
        for (int l = 0; l < 3; l++) begin
            nmag[l] = sq_n_reg[32][l][35] ? 36'(-sq_n_reg[32][l]) : 36'(sq_n_reg[32][l]);
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            pp_degen_reg <= sq_bad_reg[32] || (dd < (32'd1 << (INT_FRAC - 10)));
            pp_real_reg  <= realm[32:31] != 2'b00 ? 32'h7FFF_FFFF : realm[31:0];
            pp_dv_reg    <= {dd, 1'b0};
            for (int l = 0; l < 3; l++) begin
                pp_num_reg[l] <= ({32'b0, nmag[l][32:0]} << frac_bits_reg) + {33'b0, dd};
                pp_neg_reg[l] <= sq_n_reg[32][l][35];
            end
        end
    end

    // Divider arrays (index 0 = overflow check stage)
    logic [64:0] dr_rem_reg [0:32][0:2];
    logic [31:0] dr_q_reg   [0:32][0:2];
    logic        dr_ovf_reg [0:32][0:2];
    logic        dr_neg_reg [0:32][0:2];
    logic [32:0] dr_dv_reg  [0:32];
    logic        dr_degen_reg [0:32];
    logic [31:0] dr_real_reg  [0:32];

    // Quotient overflow check: quotient of 2^32 or more always saturates
    always_ff @(posedge aclk) begin
        if (en) begin
            dr_dv_reg[0]    <= pp_dv_reg;
            dr_degen_reg[0] <= pp_degen_reg;
            dr_real_reg[0]  <= pp_real_reg;
            for (int l = 0; l < 3; l++) begin
                dr_rem_reg[0][l] <= pp_num_reg[l];
                dr_q_reg[0][l]   <= '0;
                dr_ovf_reg[0][l] <= (pp_num_reg[l] >= {pp_dv_reg, 32'b0});
                dr_neg_reg[0][l] <= pp_neg_reg[l];
            end
        end
    end

    // Restoring division, one quotient bit per stage
    for (genvar m = 1; m <= 32; m++) begin : g_div
        localparam int B = 32 - m;
        logic [64:0] shdv;
        assign shdv = {32'b0, dr_dv_reg[m-1]} << B;
        always_ff @(posedge aclk) begin
            if (en) begin
                dr_dv_reg[m]    <= dr_dv_reg[m-1];
                dr_degen_reg[m] <= dr_degen_reg[m-1];
                dr_real_reg[m]  <= dr_real_reg[m-1];
                for (int l = 0; l < 3; l++) begin
                    if (dr_rem_reg[m-1][l] >= shdv) begin
                        dr_rem_reg[m][l] <= dr_rem_reg[m-1][l] - shdv;
                        dr_q_reg[m][l]   <= dr_q_reg[m-1][l] | (32'd1 << B);
                    end else begin
                        dr_rem_reg[m][l] <= dr_rem_reg[m-1][l];
                        dr_q_reg[m][l]   <= dr_q_reg[m-1][l];
                    end
                    dr_ovf_reg[m][l] <= dr_ovf_reg[m-1][l];
                    dr_neg_reg[m][l] <= dr_neg_reg[m-1][l];
                end
            end
        end
    end

    // Sign and saturation to 32 bits
    function automatic logic [31:0] sat_part(input logic [31:0] q, input logic ovf,
                                             input logic neg);
        logic [31:0] mag;
        if (neg) begin
            mag = (ovf || q > 32'h8000_0000) ? 32'h8000_0000 : q;
            return 32'd0 - mag;
        end
        return (ovf || q[31]) ? 32'h7FFF_FFFF : q;
    endfunction

    // Output register
    logic [31:0] out_real_reg;
    logic [31:0] out_part_reg [0:2];
    logic        out_degen_reg;

    always_ff @(posedge aclk) begin
        if (en) begin
            out_degen_reg <= dr_degen_reg[32];
            out_real_reg  <= dr_degen_reg[32] ? 32'd0 : dr_real_reg[32];
            for (int l = 0; l < 3; l++) begin
                out_part_reg[l] <= dr_degen_reg[32] ? 32'd0 :
                    sat_part(dr_q_reg[32][l], dr_ovf_reg[32][l], dr_neg_reg[32][l]);
            end
        end
    end

    assign m_real_part  = out_real_reg;
    assign m_i_part     = out_part_reg[0];
    assign m_j_part     = out_part_reg[1];
    assign m_k_part     = out_part_reg[2];
    assign m_degenerate = out_degen_reg;

endmodule

FILE: design/etq_sincos.sv
// ============================================================================
// etq_sincos: pipelined sine and cosine of one angle in 1/64 degree units
// Wraps the angle, folds it to the first octant, converts to radians and runs
// the Horner series for sine and cosine side by side, two stages per term.
// Advances when en is high.
// ============================================================================
module etq_sincos (
    input  logic                aclk,
    input  logic                en,
    input  logic signed [15:0]  angle,
    output etq_pkg::trig_t      sin_out,
    output etq_pkg::trig_t      cos_out
);
    import etq_pkg::*;

    typedef enum logic [1:0] {QUAD_0, QUAD_1, QUAD_2, QUAD_3} quad_t;

    // Stage 1: wrap to one turn
    logic [16:0] ap;
    logic [14:0] r_next;
    logic [14:0] r_reg;

    always_comb begin
        ap = {angle[15], angle} + 17'd46080;
        if (ap >= 17'd69120) begin
            r_next = 15'(ap - 17'd69120);
        end else if (ap >= 17'd46080) begin
            r_next = 15'(ap - 17'd46080);
        end else if (ap >= 17'd23040) begin
            r_next = 15'(ap - 17'd23040);
        end else begin
            r_next = 15'(ap);
        end
    end

    // Stage 2: quadrant, offset and octant fold
    quad_t       q_next;
    logic [12:0] t;
    logic [11:0] u_next;
    logic        sw_next;
    logic [11:0] u_reg;

    always_comb begin
        if (r_reg >= 15'd17280) begin
            q_next = QUAD_3;
            t      = 13'(r_reg - 15'd17280);
        end else if (r_reg >= 15'd11520) begin
            q_next = QUAD_2;
            t      = 13'(r_reg - 15'd11520);
        end else if (r_reg >= 15'd5760) begin
            q_next = QUAD_1;
            t      = 13'(r_reg - 15'd5760);
        end else begin
            q_next = QUAD_0;
            t      = 13'(r_reg);
        end
        sw_next = (t > 13'd2880);
        u_next  = sw_next ? 12'(13'd5760 - t) : 12'(t);
    end

    // Carried along the series stages (index 0 = radians stage)
    quad_t       q_a  [0:13];
    logic        sw_a [0:13];
    logic [29:0] x_a  [0:11];
    logic [29:0] x2_a [1:11];
    logic [30:0] ps_a [1:11];
    logic [30:0] pc_a [1:11];

    // Radians and its square
    logic [60:0] xprod;
    logic [59:0] x2prod;
    assign xprod  = 61'(u_reg) * 61'(UNIT_Q60) + (61'd1 << 29);
    assign x2prod = 60'(x_a[0]) * 60'(x_a[0]) + (60'd1 << 29);

    always_ff @(posedge aclk) begin
        if (en) begin
            r_reg    <= r_next;
            u_reg    <= u_next;
            sw_a[13] <= sw_next;
            q_a[13]  <= q_next;
            x_a[0]   <= xprod[59:30];
            sw_a[0]  <= sw_a[13];
            q_a[0]   <= q_a[13];
            x_a[1]   <= x_a[0];
            x2_a[1]  <= x2prod[59:30];
            ps_a[1]  <= ONE_Q;
            pc_a[1]  <= ONE_Q;
            sw_a[1]  <= sw_a[0];
            q_a[1]   <= q_a[0];
        end
    end

    // Horner series: even stage multiplies by x2, odd stage divides and subtracts
    for (genvar j = 2; j <= 11; j++) begin : g_term
        localparam int K = (j - 2) / 2;
        if (((j - 2) % 2) == 0) begin : g_mul
            logic [60:0] sprod;
            logic [60:0] cprod;
            assign sprod = 61'(x2_a[j-1]) * 61'(ps_a[j-1]) + (61'd1 << 29);
            assign cprod = 61'(x2_a[j-1]) * 61'(pc_a[j-1]) + (61'd1 << 29);
            always_ff @(posedge aclk) begin
                if (en) begin
                    ps_a[j] <= {1'b0, sprod[59:30]};
                    pc_a[j] <= {1'b0, cprod[59:30]};
                end
            end
        end else begin : g_div
            logic [66:0] sprod;
            logic [66:0] cprod;
            assign sprod = 67'(ps_a[j-1] + 31'(SIN_HALF[K])) * 67'(SIN_RECIP[K]);
            assign cprod = 67'(pc_a[j-1] + 31'(COS_HALF[K])) * 67'(COS_RECIP[K]);
            always_ff @(posedge aclk) begin
                if (en) begin
                    ps_a[j] <= ONE_Q - 31'(sprod[66:RECIP_SHIFT]);
                    pc_a[j] <= ONE_Q - 31'(cprod[66:RECIP_SHIFT]);
                end
            end
        end
        always_ff @(posedge aclk) begin
            if (en) begin
                x_a[j]  <= x_a[j-1];
                x2_a[j] <= x2_a[j-1];
                sw_a[j] <= sw_a[j-1];
                q_a[j]  <= q_a[j-1];
            end
        end
    end

    // Final series step: sin = x*p, cos = 1 - x2*p/2
    logic [60:0] sfin;
    logic [60:0] cfin;
    logic [30:0] sb_reg;
    logic [30:0] cb_reg;
    assign sfin = 61'(x_a[11]) * 61'(ps_a[11]) + (61'd1 << 29);
    assign cfin = 61'(x2_a[11]) * 61'(pc_a[11]) + (61'd1 << 30);

    always_ff @(posedge aclk) begin
        if (en) begin
            sb_reg   <= sfin[60:30];
            cb_reg   <= ONE_Q - {1'b0, cfin[60:31]};
            sw_a[12] <= sw_a[11];
            q_a[12]  <= q_a[11];
        end
    end

    // Undo the octant fold and map the quadrant
    trig_t s0;
    trig_t c0;
    trig_t sin_reg;
    trig_t cos_reg;

    always_comb begin
        s0 = sw_a[12] ? trig_t'({1'b0, cb_reg}) : trig_t'({1'b0, sb_reg});
        c0 = sw_a[12] ? trig_t'({1'b0, sb_reg}) : trig_t'({1'b0, cb_reg});
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            unique case (q_a[12])
                QUAD_0: begin sin_reg <= s0;  cos_reg <= c0;  end
                QUAD_1: begin sin_reg <= c0;  cos_reg <= -s0; end
                QUAD_2: begin sin_reg <= -s0; cos_reg <= -c0; end
                QUAD_3: begin sin_reg <= -c0; cos_reg <= s0;  end
                default: begin sin_reg <= s0; cos_reg <= c0;  end
            endcase
        end
    end

    assign sin_out = sin_reg;
    assign cos_out = cos_reg;

endmodule

FILE: design/etq_checker.sv
// ============================================================================
// etq_props: port-level checks for the Euler to quaternion block
// Watches the top-level ports only; attached by bind.
// ============================================================================
module etq_props (
    input logic               aclk,
    input logic               aresetn,
    input logic               s_ready,
    input logic               m_valid,
    input logic               m_ready,
    input logic signed [31:0] m_real_part,
    input logic signed [31:0] m_i_part,
    input logic signed [31:0] m_j_part,
    input logic signed [31:0] m_k_part,
    input logic               m_degenerate
);

    // held result stays valid and keeps its four parts
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ready) |=> (m_valid && $stable(m_real_part) && $stable(m_i_part)
                                   && $stable(m_j_part) && $stable(m_k_part)))
        else $error("result changed while stalled");

    // input side only backs off when a result is held
    a_ready: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_ready |-> (m_valid && !m_ready))
        else $error("input stalled without output backpressure");

    // degenerate result carries all-zero parts
    a_degen: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_degenerate) |-> (m_real_part == 32'sd0 && m_i_part == 32'sd0
                                       && m_j_part == 32'sd0 && m_k_part == 32'sd0))
        else $error("degenerate result with nonzero parts");

    // real part of a valid result is never negative
    a_real: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> !m_real_part[31])
        else $error("negative real part");

endmodule

bind euler_to_quaternion_fixed_top etq_props u_etq_props (
    .aclk         (aclk),
    .aresetn      (aresetn),
    .s_ready      (s_ready),
    .m_valid      (m_valid),
    .m_ready      (m_ready),
    .m_real_part  (m_real_part),
    .m_i_part     (m_i_part),
    .m_j_part     (m_j_part),
    .m_k_part     (m_k_part),
    .m_degenerate (m_degenerate)
);

FILE: bench/etq_checker.sv
// ============================================================================
// etq_checker: scoreboard for the Euler angle to quaternion converter
// Watches both channels, computes the expected quaternion for every accepted
// request in fixed point and compares each returned result field by field.
// ============================================================================
module etq_checker (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               cfg_wr_en,
    input  logic [4:0]         cfg_wr_data,
    input  logic               s_valid,
    input  logic               s_ready,
    input  logic signed [15:0] s_angle_x,
    input  logic signed [15:0] s_angle_y,
    input  logic signed [15:0] s_angle_z,
    input  logic               m_valid,
    input  logic               m_ready,
    input  logic signed [31:0] m_real_part,
    input  logic signed [31:0] m_i_part,
    input  logic signed [31:0] m_j_part,
    input  logic signed [31:0] m_k_part,
    input  logic               m_degenerate,
    output int                 errors,
    output int                 pending,
    output int                 results_seen,
    output int                 degenerate_seen
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int FQ = 30;
    localparam longint ONE = 64'sd1 << FQ;
    localparam logic [63:0] PI60 = 64'h3243_F6A8_885A_308D;
    localparam logic [63:0] RAD_STEP = (PI60 + 64'd5760) / 64'd11520;

    typedef struct {
        logic signed [31:0] w;
        logic signed [31:0] qi;
        logic signed [31:0] qj;
        logic signed [31:0] qk;
        logic               degen;
    } quat_t;

    quat_t quat_queue[$];
    logic [4:0] frac_sel;

    function automatic logic [63:0] round_shift(logic [63:0] v, int s);
        return (v + (64'd1 << (s - 1))) >> s;
    endfunction

    function automatic longint qmul(longint a, longint b);
        return (a * b + (64'sd1 << (FQ - 1))) >>> FQ;
    endfunction

    // series evaluation for an offset in [0, 2880]
    task automatic base_trig(input longint u, output longint sv, output longint cv);
        logic [63:0] x, x2, p, v;
        longint sd[5], cd[5];
        sd = '{110, 72, 42, 20, 6};
        cd = '{132, 90, 56, 30, 12};
        x  = round_shift(u * RAD_STEP, 60 - FQ);
        x2 = round_shift(x * x, FQ);
        p  = ONE;
        for (int k = 0; k < 5; k++) begin
            v = round_shift(x2 * p, FQ);
            p = ONE - (v + sd[k] / 2) / sd[k];
        end
        sv = round_shift(x * p, FQ);
        p = ONE;
        for (int k = 0; k < 5; k++) begin
            v = round_shift(x2 * p, FQ);
            p = ONE - (v + cd[k] / 2) / cd[k];
        end
        cv = ONE - round_shift(x2 * p, FQ + 1);
    endtask

    task automatic angle_trig(input logic signed [15:0] a, output longint s, output longint c);
        int r, q, t;
        longint sb, cb;
        r = int'(a) % 23040;
        if (r < 0) r += 23040;
        q = r / 5760;
        t = r % 5760;
        if (t <= 2880) base_trig(t, sb, cb);
        else base_trig(5760 - t, cb, sb);
        case (q)
            0: begin s = sb; c = cb; end
            1: begin s = cb; c = -sb; end
            2: begin s = -sb; c = -cb; end
            default: begin s = -cb; c = sb; end
        endcase
    endtask

    function automatic logic [63:0] int_sqrt(logic [63:0] n);
        logic [63:0] res, bt;
        res = 0;
        bt = 64'd1 << 62;
        while (bt > n) bt >>= 2;
        while (bt != 0) begin
            if (n >= res + bt) begin
                n -= res + bt;
                res = (res >> 1) + bt;
            end else begin
                res >>= 1;
            end
            bt >>= 2;
        end
        return res;
    endfunction

    function automatic logic signed [31:0] clamp32(logic [63:0] mag, logic neg);
        if (neg) begin
            if (mag > 64'h8000_0000) mag = 64'h8000_0000;
            return 32'(-mag);
        end
        if (mag > 64'h7FFF_FFFF) mag = 64'h7FFF_FFFF;
        return 32'(mag);
    endfunction

    function automatic logic signed [31:0] scale_part(longint n, logic [63:0] d, int fb);
        logic [63:0] mag;
        mag = (n < 0) ? 64'(-n) : 64'(n);
        return clamp32(((mag << fb) + d) / (2 * d), n < 0);
    endfunction

    task automatic predict_quat(input logic signed [15:0] ax, input logic signed [15:0] ay,
                                input logic signed [15:0] az, input int fb,
                                output quat_t qo);
        longint s1, c1, s2, c2, s3, c3, rad, ni, nj, nk;
        logic [63:0] d, wmag;
        angle_trig(ay, s1, c1);
        angle_trig(az, s2, c2);
        angle_trig(ax, s3, c3);
        rad = ONE + qmul(c1, c2) + qmul(c1, c3) - qmul(qmul(s1, s2), s3) + qmul(c2, c3);
        d = 0;
        if (rad > 0) d = int_sqrt(64'(rad) << FQ);
        qo = '{0, 0, 0, 0, 1'b1};
        if (rad <= 0 || d < (64'd1 << (FQ - 10))) return;
        ni = qmul(c2, s3) + qmul(c1, s3) + qmul(qmul(s1, s2), c3);
        nj = qmul(s1, c2) + qmul(s1, c3) + qmul(qmul(c1, s2), s3);
        nk = qmul(qmul(c1, s2), c3) + s2 - qmul(s1, s3);
        if (fb >= FQ + 1) wmag = d << (fb - FQ - 1);
        else wmag = round_shift(d, FQ + 1 - fb);
        qo.w = clamp32(wmag, 1'b0);
        qo.qi = scale_part(ni, d, fb);
        qo.qj = scale_part(nj, d, fb);
        qo.qk = scale_part(nk, d, fb);
        qo.degen = 1'b0;
    endtask

    assign pending = quat_queue.size();

    // predict on each accepted request, compare on each accepted result
    always @(posedge aclk) begin
        quat_t q, e;
        if (!aresetn) begin
            frac_sel <= 5'd30;
            errors = 0;
            results_seen = 0;
            degenerate_seen = 0;
        end else begin
            if (cfg_wr_en) frac_sel <= cfg_wr_data;
            if (s_valid && s_ready) begin
                predict_quat(s_angle_x, s_angle_y, s_angle_z, frac_sel, q);
                quat_queue.push_back(q);
            end
            if (m_valid && m_ready) begin
                results_seen++;
                if (m_degenerate) degenerate_seen++;
                if (quat_queue.size() == 0) begin
                    $error("result with no request outstanding");
                    errors++;
                end else begin
                    e = quat_queue.pop_front();
                    if (m_real_part !== e.w) begin
                        $error("real_part exp %0d got %0d", e.w, m_real_part);
                        errors++;
                    end
                    if (m_i_part !== e.qi) begin
                        $error("i_part exp %0d got %0d", e.qi, m_i_part);
                        errors++;
                    end
                    if (m_j_part !== e.qj) begin
                        $error("j_part exp %0d got %0d", e.qj, m_j_part);
                        errors++;
                    end
                    if (m_k_part !== e.qk) begin
                        $error("k_part exp %0d got %0d", e.qk, m_k_part);
                        errors++;
                    end
                    if (m_degenerate !== e.degen) begin
                        $error("degenerate exp %0b got %0b", e.degen, m_degenerate);
                        errors++;
                    end
                end
            end
        end
    end
endmodule

FILE: bench/tb_euler_to_quaternion_fixed_top.sv
// ============================================================================
// tb_euler_to_quaternion_fixed_top: converter testbench
// Drives directed and random angle triples under several fraction-bit settings
// with random idling and back-pressure; the checker scores every result.
// ============================================================================
module tb_euler_to_quaternion_fixed_top;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int LATENCY = 86;
    localparam longint CYCLE_LIMIT = 400000;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic cfg_wr_en = 1'b0;
    logic [4:0] cfg_wr_data = 5'd0;
    logic s_valid = 1'b0;
    logic s_ready;
    logic signed [15:0] s_angle_x = '0, s_angle_y = '0, s_angle_z = '0;
    logic m_valid;
    logic m_ready = 1'b0;
    logic signed [31:0] m_real_part, m_i_part, m_j_part, m_k_part;
    logic m_degenerate;
    int errors, pending, results_seen, degenerate_seen;
    longint cycle_count = 0;
    int sent = 0;
    bit calm_mode = 0;
    bit hold_off = 0;

    always #5 aclk = ~aclk;

    euler_to_quaternion_fixed_top dut (.*);

    etq_checker u_checker (.*);

    // run timeout
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("tb_euler_to_quaternion_fixed_top: done, errors");
            $finish;
        end
    end

    // result side back-pressure
    always @(posedge aclk) begin
        if (!aresetn || hold_off) m_ready <= 1'b0;
        else m_ready <= calm_mode || ($urandom_range(99) >= 15);
    end

    // offer one request and wait for it to be taken; valid stays up for a
    // request that follows directly
    task automatic send_angles(input logic signed [15:0] ax, input logic signed [15:0] ay,
                               input logic signed [15:0] az);
        while (!calm_mode && $urandom_range(99) < 15) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_angle_x <= ax;
        s_angle_y <= ay;
        s_angle_z <= az;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        sent++;
    endtask

    task automatic drain_and_write(input logic [4:0] fb);
        s_valid <= 1'b0;
        @(posedge aclk);
        while (pending != 0) @(posedge aclk);
        repeat (LATENCY + 4) @(posedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_wr_data <= fb;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        @(posedge aclk);
    endtask

    function automatic logic signed [15:0] rand_angle();
        case ($urandom_range(3))
            0: return 16'($urandom);
            1: return 16'(int'($urandom_range(46080)) - 23040);
            2: return 16'(int'($urandom_range(8)) * 2880 - 11520);
            default: return 16'(int'($urandom_range(4)) * 5760 - 11520
                                + int'($urandom_range(6)) - 3);
        endcase
    endfunction

    initial begin
        logic [4:0] fb_plan[6];
        fb_plan = '{5'd30, 5'd1, 5'd16, 5'd0, 5'd31, 5'd24};
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed: extremes, quadrant edges, octant mirror, degenerate poses
        send_angles(0, 0, 0);
        send_angles(23040, 23040, 23040);
        send_angles(-23040, -23040, -23040);
        send_angles(16'sh7FFF, 16'sh7FFF, 16'sh7FFF);
        send_angles(16'sh8000, 16'sh8000, 16'sh8000);
        send_angles(16'sh7FFF, 16'sh8000, 0);
        send_angles(2880, 2881, 2879);
        send_angles(5760, 11520, 17280);
        send_angles(11520, 0, 0);
        send_angles(0, 11520, 0);
        send_angles(0, 0, 11520);
        send_angles(11520, 11520, 0);
        send_angles(0, 11520, 11520);
        send_angles(11520, 0, 11520);
        send_angles(11520, 11520, 11520);
        send_angles(-5760, 5760, -5760);
        send_angles(16'shFFFF, 1, 16'shAAAA);
        send_angles(16'sh5555, 16'sh5555, 16'shAAAA);

        for (int ph = 0; ph < 6; ph++) begin
            drain_and_write(fb_plan[ph]);
            calm_mode = (ph == 2);
            for (int n = 0; n < 130; n++) begin
                if (ph == 3 && n == 40) begin
                    // long receiver hold-off while requests keep coming
                    fork
                        begin
                            hold_off = 1;
                            repeat (300) @(posedge aclk);
                            hold_off = 0;
                        end
                    join_none
                end
                if (ph == 4 && n == 60) begin
                    // sender pause until everything is back
                    s_valid <= 1'b0;
                    @(posedge aclk);
                    while (pending != 0) @(posedge aclk);
                end
                send_angles(rand_angle(), rand_angle(), rand_angle());
            end
        end
        calm_mode = 0;
        s_valid <= 1'b0;
        @(posedge aclk);

        while (pending != 0) @(posedge aclk);
        repeat (LATENCY + 10) @(posedge aclk);
        $display("covered %0d requests, %0d results (%0d degenerate), six precisions",
                 sent, results_seen, degenerate_seen);
        if (errors == 0 && pending == 0)
            $display("tb_euler_to_quaternion_fixed_top: done, clean");
        else
            $display("tb_euler_to_quaternion_fixed_top: done, errors");
        $finish;
    end
endmodule
